@@ design/sbmf_pkg.sv @@
package sbmf_pkg;

  localparam int unsigned MaxBeamsDefault   = 4096;
  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned NumCoefs  = 13;
  localparam int unsigned AtanLen   = 24;
  localparam logic [29:0] GainInvQ30 = 30'd652032874;
  localparam int unsigned QueueDepth = 2;

  // Coefficient indexes
  localparam logic [3:0] CoefRmin   = 4'd0;
  localparam logic [3:0] CoefRmax   = 4'd1;
  localparam logic [3:0] CoefAStart = 4'd2;
  localparam logic [3:0] CoefAStep  = 4'd3;
  localparam logic [3:0] CoefR00    = 4'd4;
  localparam logic [3:0] CoefTx     = 4'd10;

  // Configuration register indexes
  localparam logic [2:0] RegMinX   = 3'd0;
  localparam logic [2:0] RegMaxX   = 3'd1;
  localparam logic [2:0] RegMinY   = 3'd2;
  localparam logic [2:0] RegMaxY   = 3'd3;
  localparam logic [2:0] RegMinZ   = 3'd4;
  localparam logic [2:0] RegMaxZ   = 3'd5;
  localparam logic [2:0] RegInvert = 3'd6;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqCoef   = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [3:0]        coef_index;
    logic signed [31:0] coef_value;
    logic [15:0]       range_mm;
    logic              range_finite;
    logic              scan_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] range_out;
    logic        out_finite;
    logic        masked;
    logic [11:0] beam_index;
  } out_item_t;

  // Work handed from front to back
  typedef struct packed {
    logic        need_calc;
    logic [15:0] range_mm;
    logic        range_finite;
    logic [15:0] angle;
    logic [11:0] beam;
  } job_t;

  typedef struct packed {
    logic signed [15:0] min_x;
    logic signed [15:0] max_x;
    logic signed [15:0] min_y;
    logic signed [15:0] max_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_z;
    logic               invert;
  } box_cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCALE,
    BK_ROT,
    BK_MUL,
    BK_SUM,
    BK_TEST,
    BK_OUT
  } bk_state_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000; 5'd1:  v = 32'h12E4051E; 5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4; 5'd4:  v = 32'h028B0D43; 5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E; 5'd7:  v = 32'h00517C55; 5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F; 5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3; 5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D; 5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518; 5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146; 5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ design/sbmf_front.sv @@
module sbmf_front #(
  parameter int unsigned MAX_BEAMS = sbmf_pkg::MaxBeamsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sbmf_pkg::in_item_t  item,
  input  logic                item_vld,
  output logic                item_rdy,
  output sbmf_pkg::job_t      job,
  output logic                job_vld,
  input  logic                job_rdy,
  input  logic                down_busy,
  output logic [31:0]         coef_rd [6],
  output logic [31:0]         coef_tr [3]
);
  localparam logic [11:0] Limit = (MAX_BEAMS - 1 < 4095) ? 12'(MAX_BEAMS - 1) : 12'd4095;

  logic [31:0] coefs_r [sbmf_pkg::NumCoefs];
  logic [11:0] beam_cnt_r;
  logic [11:0] beam;
  logic        in_range;
  logic [15:0] angle;

  // Job register: one entry, loaded when free or drained this cycle
  sbmf_pkg::job_t job_r;
  logic           job_vld_r;
  // Angle product is registered in a second phase
  logic           phase_r;
  sbmf_pkg::job_t hold_r;
  logic [15:0]    prod_r;

  // Hold coefficient writes until no sample is left downstream
  assign item_rdy = !phase_r && ((item.req_type == sbmf_pkg::ReqCoef)
      ? (!job_vld_r && !down_busy) : (!job_vld_r || job_rdy));
  assign beam = item.scan_start ? 12'd0 : beam_cnt_r;
  assign in_range = item.range_finite &&
      ($signed({16'd0, item.range_mm}) >= $signed(coefs_r[sbmf_pkg::CoefRmin])) &&
      ($signed({16'd0, item.range_mm}) <= $signed(coefs_r[sbmf_pkg::CoefRmax]));
  assign angle = coefs_r[sbmf_pkg::CoefAStart][15:0] + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbmf_pkg::NumCoefs; i++) coefs_r[i] <= '0;
      beam_cnt_r <= '0;
      job_vld_r  <= 1'b0;
      phase_r    <= 1'b0;
    end else begin
      // finish angle from the registered product
      if (phase_r && (!job_vld_r || job_rdy)) begin
        job_r     <= '{need_calc: hold_r.need_calc, range_mm: hold_r.range_mm,
                       range_finite: hold_r.range_finite, angle: angle,
                       beam: hold_r.beam};
        job_vld_r <= 1'b1;
        phase_r   <= 1'b0;
      end else if (job_vld_r && job_rdy) begin
        job_vld_r <= 1'b0;
      end
      if (item_vld && item_rdy) begin
        if (item.req_type == sbmf_pkg::ReqCoef) begin
          if (item.coef_index < 4'(sbmf_pkg::NumCoefs))
            coefs_r[item.coef_index] <= item.coef_value;
        end else begin
          hold_r.need_calc    <= in_range;
          hold_r.range_mm     <= item.range_mm;
          hold_r.range_finite <= item.range_finite;
          hold_r.angle        <= '0;
          hold_r.beam         <= beam;
          prod_r  <= 16'(beam * coefs_r[sbmf_pkg::CoefAStep][15:0]);
          phase_r <= 1'b1;
          beam_cnt_r <= (beam < Limit) ? beam + 12'd1 : beam;
        end
      end
    end
  end

  assign job     = job_r;
  assign job_vld = job_vld_r;
  for (genvar g = 0; g < 6; g++) begin : g_rot
    assign coef_rd[g] = coefs_r[sbmf_pkg::CoefR00 + g];
  end
  for (genvar g = 0; g < 3; g++) begin : g_tr
    assign coef_tr[g] = coefs_r[sbmf_pkg::CoefTx + g];
  end
endmodule

@@ design/sbmf_queue.sv @@
module sbmf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  sbmf_pkg::job_t wr_data,
  input  logic           wr_vld,
  output logic           wr_rdy,
  output sbmf_pkg::job_t rd_data,
  output logic           rd_vld,
  input  logic           rd_rdy
);
  sbmf_pkg::job_t mem_r [sbmf_pkg::QueueDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_rdy  = cnt_r != 2'd2;
  assign rd_vld  = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_vld && wr_rdy;
  assign rd = rd_vld && rd_rdy;

  // Hold jobs in a two-entry ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) begin
        mem_r[wp_r] <= wr_data;
        wp_r <= ~wp_r;
      end
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  property p_no_over;
    @(posedge clk) disable iff (!rst_n) cnt_r == 2'd2 |-> !wr;
  endproperty
  a_no_over: assert property (p_no_over) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");
  a_empty_rd: assert property (@(posedge clk) disable iff (!rst_n) cnt_r == 2'd0 |-> !rd)
    else $error("queue underflow");
endmodule

@@ design/sbmf_back.sv @@
module sbmf_back #(
  parameter int unsigned CORDIC_STEPS = sbmf_pkg::CordicStepsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sbmf_pkg::job_t      job,
  input  logic                job_vld,
  output logic                job_rdy,
  input  logic [31:0]         coef_rd [6],
  input  logic [31:0]         coef_tr [3],
  input  sbmf_pkg::box_cfg_t  box,
  output sbmf_pkg::out_item_t res,
  output logic                res_vld,
  input  logic                res_rdy
);
  localparam int Steps = (CORDIC_STEPS < sbmf_pkg::AtanLen) ? CORDIC_STEPS : sbmf_pkg::AtanLen;

  sbmf_pkg::bk_state_t st_r, st_nxt;
  sbmf_pkg::job_t j_r;
  logic signed [33:0] x_r, y_r;
  logic signed [33:0] z_r;
  logic [4:0]  it_r;
  logic        neg_r;
  logic [15:0] ang_r;
  logic signed [20:0] xm_r, ym_r;
  logic [1:0]  ax_r;
  logic signed [52:0] pa_r, pb_r;
  logic signed [34:0] p_r [3];
  logic        masked_r;
  sbmf_pkg::out_item_t out_r;
  logic        out_vld_r;

  logic signed [46:0] scaled;
  logic signed [33:0] dx, dy;
  logic signed [33:0] atan_v;
  logic signed [53:0] sum;
  logic signed [39:0] rsh;
  logic signed [33:0] xr, yr;
  logic in_box;

  assign scaled = $signed({1'b0, j_r.range_mm}) * $signed({1'b0, sbmf_pkg::GainInvQ30});
  assign dx = y_r >>> it_r;
  assign dy = x_r >>> it_r;
  assign atan_v = $signed({2'b00, sbmf_pkg::atan_entry(it_r)});
  assign xr = (x_r + 34'sd8192) >>> 14;
  assign yr = (y_r + 34'sd8192) >>> 14;
  assign sum = 54'(pa_r) + 54'(pb_r) + 54'sd8192;
  assign rsh = 40'(sum >>> 14);
  assign in_box = p_r[0] >= 35'(box.min_x) && p_r[0] <= 35'(box.max_x) &&
                  p_r[1] >= 35'(box.min_y) && p_r[1] <= 35'(box.max_y) &&
                  p_r[2] >= 35'(box.min_z) && p_r[2] <= 35'(box.max_z);

  assign job_rdy = (st_r == sbmf_pkg::BK_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= sbmf_pkg::BK_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sbmf_pkg::BK_IDLE: if (job_vld) st_nxt = job.need_calc ? sbmf_pkg::BK_SCALE
                                                              : sbmf_pkg::BK_OUT;
      sbmf_pkg::BK_SCALE: st_nxt = sbmf_pkg::BK_ROT;
      sbmf_pkg::BK_ROT: if (it_r == 5'(Steps - 1)) st_nxt = sbmf_pkg::BK_MUL;
      sbmf_pkg::BK_MUL: st_nxt = sbmf_pkg::BK_SUM;
      sbmf_pkg::BK_SUM: if (ax_r == 2'd2) st_nxt = sbmf_pkg::BK_TEST;
                        else st_nxt = sbmf_pkg::BK_MUL;
      sbmf_pkg::BK_TEST: st_nxt = sbmf_pkg::BK_OUT;
      sbmf_pkg::BK_OUT: if (!out_vld_r || res_rdy) st_nxt = sbmf_pkg::BK_IDLE;
      default: st_nxt = sbmf_pkg::BK_IDLE;
    endcase
  end

  // Datapath: load, then scale, iterate, transform, test (computed samples only), output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && res_rdy && st_r != sbmf_pkg::BK_OUT) out_vld_r <= 1'b0;
      unique case (st_r)
        sbmf_pkg::BK_IDLE: if (job_vld) begin
          j_r      <= job;
          masked_r <= 1'b0;
          neg_r    <= job.angle[15] ^ job.angle[14];
          ang_r    <= (job.angle[15] ^ job.angle[14]) ? job.angle ^ 16'h8000 : job.angle;
        end
        sbmf_pkg::BK_SCALE: begin
          x_r  <= neg_r ? -34'(scaled >>> 16) : 34'(scaled >>> 16);
          y_r  <= '0;
          z_r  <= 34'($signed(ang_r)) <<< 16;
          it_r <= '0;
        end
        sbmf_pkg::BK_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - atan_v;
          end else begin
            x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + atan_v;
          end
          it_r <= it_r + 5'd1;
          if (it_r == 5'(Steps - 1)) ax_r <= '0;
        end
        sbmf_pkg::BK_MUL: begin
          if (ax_r == '0) begin
            xm_r <= 21'(xr); ym_r <= 21'(yr);
            pa_r <= $signed(coef_rd[0]) * 21'(xr);
            pb_r <= $signed(coef_rd[1]) * 21'(yr);
          end else begin
            pa_r <= $signed(coef_rd[{ax_r, 1'b0}]) * xm_r;
            pb_r <= $signed(coef_rd[{ax_r, 1'b1}]) * ym_r;
          end
        end
        sbmf_pkg::BK_SUM: begin
          p_r[ax_r] <= 35'(rsh) + 35'($signed(coef_tr[ax_r]));
          ax_r <= ax_r + 2'd1;
        end
        sbmf_pkg::BK_TEST: masked_r <= in_box != box.invert;
        sbmf_pkg::BK_OUT: if (!out_vld_r || res_rdy) begin
          out_r.range_out  <= j_r.range_mm;
          out_r.out_finite <= j_r.range_finite;
          out_r.masked     <= masked_r;
          out_r.beam_index <= j_r.beam;
          out_vld_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign res     = out_r;
  assign res_vld = out_vld_r;

  a_rdy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_rdy |-> st_r == sbmf_pkg::BK_IDLE) else $error("job taken while busy");
  a_mask_calc: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == sbmf_pkg::BK_OUT && !j_r.need_calc |-> !masked_r)
    else $error("mask set on pass-through sample");
  a_iter: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == sbmf_pkg::BK_ROT |-> it_r < 5'(Steps)) else $error("iteration overrun");
endmodule

@@ design/scan_box_mask_filter.sv @@
// A pass-through sample goes from the front to the queue and straight to the
//   back part's output register; a computed one first passes scale, the
//   iterative CORDIC and the shared two-multiplier transform and box test.
//   A coefficient write gives no beat and waits until the queue and the back
//   part hold no sample. The back part takes a new sample only when it is
//   idle, so one sample is finished before the next one starts.
// Reset (rst_n low, synchronous): coefficients and beam count cleared, box
//   registers to defaults, queue emptied.
module scan_box_mask_filter #(
  parameter int unsigned MAX_BEAMS    = sbmf_pkg::MaxBeamsDefault,
  parameter int unsigned CORDIC_STEPS = sbmf_pkg::CordicStepsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  sbmf_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output sbmf_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  sbmf_pkg::box_cfg_t box_r;
  logic [2:0] ridx;
  logic in_rdy, fj_vld, fj_rdy, bj_vld, bj_rdy, res_vld;
  logic down_busy;
  sbmf_pkg::job_t fj, bj;
  logic [31:0] coef_rd [6];
  logic [31:0] coef_tr [3];

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // Write box registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.min_x <= -16'sd500; box_r.max_x <= 16'sd300;
      box_r.min_y <= -16'sd350; box_r.max_y <= 16'sd350;
      box_r.min_z <= -16'sd200; box_r.max_z <= 16'sd350;
      box_r.invert <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        sbmf_pkg::RegMinX:   box_r.min_x  <= pwdata[15:0];
        sbmf_pkg::RegMaxX:   box_r.max_x  <= pwdata[15:0];
        sbmf_pkg::RegMinY:   box_r.min_y  <= pwdata[15:0];
        sbmf_pkg::RegMaxY:   box_r.max_y  <= pwdata[15:0];
        sbmf_pkg::RegMinZ:   box_r.min_z  <= pwdata[15:0];
        sbmf_pkg::RegMaxZ:   box_r.max_z  <= pwdata[15:0];
        sbmf_pkg::RegInvert: box_r.invert <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      sbmf_pkg::RegMinX:   prdata = 32'($signed(box_r.min_x));
      sbmf_pkg::RegMaxX:   prdata = 32'($signed(box_r.max_x));
      sbmf_pkg::RegMinY:   prdata = 32'($signed(box_r.min_y));
      sbmf_pkg::RegMaxY:   prdata = 32'($signed(box_r.max_y));
      sbmf_pkg::RegMinZ:   prdata = 32'($signed(box_r.min_z));
      sbmf_pkg::RegMaxZ:   prdata = 32'($signed(box_r.max_z));
      sbmf_pkg::RegInvert: prdata = {31'd0, box_r.invert};
      default:             prdata = '0;
    endcase
  end

  assign in_full   = !in_rdy;
  assign out_empty = !res_vld;
  // Samples still queued or in the back part
  assign down_busy = bj_vld || !bj_rdy;

  sbmf_front #(.MAX_BEAMS(MAX_BEAMS)) u_front (
    .clk, .rst_n, .item(in_data), .item_vld(in_push), .item_rdy(in_rdy),
    .job(fj), .job_vld(fj_vld), .job_rdy(fj_rdy), .down_busy, .coef_rd, .coef_tr
  );

  sbmf_queue u_queue (
    .clk, .rst_n, .wr_data(fj), .wr_vld(fj_vld), .wr_rdy(fj_rdy),
    .rd_data(bj), .rd_vld(bj_vld), .rd_rdy(bj_rdy)
  );

  sbmf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .job(bj), .job_vld(bj_vld), .job_rdy(bj_rdy), .coef_rd, .coef_tr,
    .box(box_r), .res(out_data), .res_vld(res_vld), .res_rdy(out_pop)
  );
endmodule

@@ dv/sbmf_checker.sv @@
`timescale 1ns / 1ps

module sbmf_checker #(
  parameter int unsigned MAX_BEAMS    = 4096,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  sbmf_pkg::in_item_t  in_data,
  input  logic                out_empty,
  input  logic                out_pop,
  input  sbmf_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  pending,
  output int                  errors,
  output int                  n_results,
  output int                  n_computed,
  output int                  n_masked
);
  localparam int unsigned BeamLimit = (MAX_BEAMS - 1 < 4095) ? MAX_BEAMS - 1 : 4095;

  logic [31:0]         scan_words [sbmf_pkg::NumCoefs];
  logic [11:0]         beam_cnt;
  sbmf_pkg::box_cfg_t  box;
  sbmf_pkg::out_item_t expected_beats [$];
  sbmf_pkg::out_item_t want;

  initial begin
    pending = 0;
    errors = 0;
    n_results = 0;
    n_computed = 0;
    n_masked = 0;
  end

  task automatic report(input string msg);
    if (errors < 20) $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  // Arctangent of 2^-i in 2^-32 turn units
  function automatic longint turn_atan(input int i);
    case (i)
      0: return 64'h20000000;  1: return 64'h12E4051E;  2: return 64'h09FB385B;
      3: return 64'h051111D4;  4: return 64'h028B0D43;  5: return 64'h0145D7E1;
      6: return 64'h00A2F61E;  7: return 64'h00517C55;  8: return 64'h0028BE53;
      9: return 64'h00145F2F;  10: return 64'h000A2F98; 11: return 64'h000517CC;
      12: return 64'h00028BE6; 13: return 64'h000145F3; 14: return 64'h0000A2FA;
      15: return 64'h0000517D; 16: return 64'h000028BE; 17: return 64'h0000145F;
      18: return 64'h00000A30; 19: return 64'h00000518; 20: return 64'h0000028C;
      21: return 64'h00000146; 22: return 64'h000000A3; 23: return 64'h00000051;
      default: return 0;
    endcase
  endfunction

  // Range and binary angle to x, y in whole millimetres
  function automatic void beam_to_xy(input logic [15:0] rng, input logic [15:0] ang,
                                     output longint xo, output longint yo);
    longint x, y, z, dx, dy;
    logic [15:0] a, folded;
    x = (longint'(rng) * longint'(sbmf_pkg::GainInvQ30)) >>> 16;
    y = 0;
    a = ang;
    folded = a + 16'h4000;
    if (folded[15]) begin
      x = -x;
      a = a ^ 16'h8000;
    end
    z = longint'($signed(a)) * 65536;
    for (int i = 0; i < CORDIC_STEPS && i < sbmf_pkg::AtanLen; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - turn_atan(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + turn_atan(i);
      end
    end
    xo = (x + 8192) >>> 14;
    yo = (y + 8192) >>> 14;
  endfunction

  // One output axis of the rigid transform
  function automatic longint move_axis(input int row, input longint x, input longint y);
    longint ra, rb;
    ra = longint'($signed(scan_words[4 + 2 * row]));
    rb = longint'($signed(scan_words[5 + 2 * row]));
    return ((ra * x + rb * y + 8192) >>> 14) + longint'($signed(scan_words[10 + row]));
  endfunction

  function automatic logic between(input longint v, input logic signed [15:0] lo,
                                   input logic signed [15:0] hi);
    return v >= longint'(lo) && v <= longint'(hi);
  endfunction

  // Expected beat for one range sample; advances the beam count
  function automatic sbmf_pkg::out_item_t mask_sample(input sbmf_pkg::in_item_t it);
    sbmf_pkg::out_item_t r;
    logic [31:0] ang;
    longint x, y;
    logic in_box;
    if (it.scan_start) beam_cnt = '0;
    r.range_out = it.range_mm;
    r.out_finite = it.range_finite;
    r.beam_index = beam_cnt;
    r.masked = 1'b0;
    if (it.range_finite &&
        longint'(it.range_mm) >= longint'($signed(scan_words[sbmf_pkg::CoefRmin])) &&
        longint'(it.range_mm) <= longint'($signed(scan_words[sbmf_pkg::CoefRmax]))) begin
      ang = scan_words[sbmf_pkg::CoefAStart] +
            {20'd0, beam_cnt} * scan_words[sbmf_pkg::CoefAStep];
      beam_to_xy(it.range_mm, ang[15:0], x, y);
      in_box = between(move_axis(0, x, y), box.min_x, box.max_x) &&
               between(move_axis(1, x, y), box.min_y, box.max_y) &&
               between(move_axis(2, x, y), box.min_z, box.max_z);
      r.masked = in_box != box.invert;
      n_computed++;
    end
    if (beam_cnt < BeamLimit) beam_cnt = beam_cnt + 1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbmf_pkg::NumCoefs; i++) scan_words[i] = '0;
      beam_cnt = '0;
      box.min_x = -16'sd500;
      box.max_x = 16'sd300;
      box.min_y = -16'sd350;
      box.max_y = 16'sd350;
      box.min_z = -16'sd200;
      box.max_z = 16'sd350;
      box.invert = 1'b0;
      expected_beats.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          sbmf_pkg::RegMinX:   box.min_x = pwdata[15:0];
          sbmf_pkg::RegMaxX:   box.max_x = pwdata[15:0];
          sbmf_pkg::RegMinY:   box.min_y = pwdata[15:0];
          sbmf_pkg::RegMaxY:   box.max_y = pwdata[15:0];
          sbmf_pkg::RegMinZ:   box.min_z = pwdata[15:0];
          sbmf_pkg::RegMaxZ:   box.max_z = pwdata[15:0];
          sbmf_pkg::RegInvert: box.invert = pwdata[0];
          default: ;
        endcase
      end
      // Predict accepted input beats
      if (in_push && !in_full) begin
        if (in_data.req_type == sbmf_pkg::ReqCoef) begin
          if (in_data.coef_index < sbmf_pkg::NumCoefs)
            scan_words[in_data.coef_index] = in_data.coef_value;
        end else begin
          expected_beats.push_back(mask_sample(in_data));
        end
      end
      // Compare accepted result beats
      if (out_pop && !out_empty) begin
        if (expected_beats.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_beats.pop_front();
          if (out_data.range_out !== want.range_out)
            report($sformatf("range_out %0d, expected %0d", out_data.range_out, want.range_out));
          if (out_data.out_finite !== want.out_finite)
            report($sformatf("out_finite %b, expected %b", out_data.out_finite, want.out_finite));
          if (out_data.masked !== want.masked)
            report($sformatf("masked %b, expected %b (beam %0d range %0d)", out_data.masked,
                             want.masked, want.beam_index, want.range_out));
          if (out_data.beam_index !== want.beam_index)
            report($sformatf("beam_index %0d, expected %0d", out_data.beam_index,
                             want.beam_index));
          n_results++;
          if (want.masked) n_masked++;
        end
      end
    end
    pending <= expected_beats.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  localparam int unsigned Beams = 4096;
  localparam int unsigned Steps = 16;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  sbmf_pkg::in_item_t  in_data = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  sbmf_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [4:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int pending, errors, n_results, n_computed, n_masked;
  int n_sent = 0;
  int burst_left = 0;

  always #1 clk = ~clk;

  scan_box_mask_filter #(.MAX_BEAMS(Beams), .CORDIC_STEPS(Steps)) dut (
    .clk, .rst_n, .in_push, .in_full, .in_data, .out_empty, .out_pop, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sbmf_checker #(.MAX_BEAMS(Beams), .CORDIC_STEPS(Steps)) u_checker (
    .clk, .rst_n, .in_push, .in_full, .in_data, .out_empty, .out_pop, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .pending, .errors, .n_results, .n_computed, .n_masked
  );

  // Receiver: periodically pick a stall style at random
  int pop_mode = 0;
  int cyc = 0;
  always @(posedge clk) begin
    cyc++;
    if (cyc % 200 == 0) pop_mode = $urandom_range(0, 2);
    case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= $urandom_range(0, 1);
      default: out_pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic sbmf_pkg::in_item_t sample_item(input logic [15:0] rng, input logic fin,
                                                     input logic st);
    sbmf_pkg::in_item_t it;
    it = '0;
    it.req_type = sbmf_pkg::ReqSample;
    it.coef_index = 4'($urandom);
    it.coef_value = $urandom;
    it.range_mm = rng;
    it.range_finite = fin;
    it.scan_start = st;
    return it;
  endfunction

  function automatic sbmf_pkg::in_item_t coef_item(input logic [3:0] idx,
                                                   input logic [31:0] val);
    sbmf_pkg::in_item_t it;
    it = '0;
    it.req_type = sbmf_pkg::ReqCoef;
    it.coef_index = idx;
    it.coef_value = val;
    it.range_mm = 16'($urandom);
    it.range_finite = $urandom_range(0, 1);
    it.scan_start = $urandom_range(0, 1);
    return it;
  endfunction

  // Push one beat, in bursts with random gaps
  task automatic send(input sbmf_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    n_sent++;
  endtask

  // Drain all results, then let a trailing coefficient write retire
  task automatic settle();
    in_push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Steps + 16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_box(input int x0, input int x1, input int y0, input int y1,
                           input int z0, input int z1, input logic inv);
    write_reg(sbmf_pkg::RegMinX, 32'(x0));
    write_reg(sbmf_pkg::RegMaxX, 32'(x1));
    write_reg(sbmf_pkg::RegMinY, 32'(y0));
    write_reg(sbmf_pkg::RegMaxY, 32'(y1));
    write_reg(sbmf_pkg::RegMinZ, 32'(z0));
    write_reg(sbmf_pkg::RegMaxZ, 32'(z1));
    write_reg(sbmf_pkg::RegInvert, {31'd0, inv});
  endtask

  function automatic logic [31:0] rand_rot();
    return 32'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  // One scan: mostly a full coefficient load then beams, sometimes noise
  task automatic rand_scan(inout int budget);
    int n;
    logic [15:0] rng;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n && budget > 0; i++, budget--) begin
        if ($urandom_range(0, 1)) send(coef_item(4'($urandom), $urandom));
        else send(sample_item(16'($urandom), $urandom_range(0, 1), $urandom_range(0, 1)));
      end
    end else begin
      send(coef_item(sbmf_pkg::CoefRmin,
                     ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 200)));
      send(coef_item(sbmf_pkg::CoefRmax, ($urandom_range(0, 9) == 0) ? 32'h7FFFFFFF
                                         : $urandom_range(500, 6000)));
      send(coef_item(sbmf_pkg::CoefAStart, $urandom));
      send(coef_item(sbmf_pkg::CoefAStep, ($urandom_range(0, 3) == 0) ? $urandom
                                          : $urandom_range(0, 600)));
      for (int i = 0; i < 6; i++) send(coef_item(sbmf_pkg::CoefR00 + 4'(i), rand_rot()));
      for (int i = 0; i < 3; i++)
        send(coef_item(sbmf_pkg::CoefTx + 4'(i), 32'(int'($urandom_range(0, 1000)) - 500)));
      budget -= 13;
      n = $urandom_range(1, 60);
      for (int i = 0; i < n && budget > 0; i++, budget--) begin
        rng = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        send(sample_item(rng, $urandom_range(0, 15) != 0, i == 0));
      end
    end
  endtask

  task automatic random_phase(input int count, input logic hold_mid);
    int budget;
    budget = count;
    while (budget > 0) begin
      rand_scan(budget);
      if (hold_mid && budget < count / 2) begin
        hold_mid = 1'b0;
        settle();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: rmax zero, so only a zero range is computed
    send(sample_item(16'd0, 1'b1, 1'b1));
    send(sample_item(16'd1, 1'b1, 1'b0));
    send(sample_item(16'hFFFF, 1'b0, 1'b0));
    // Identity transform, angle step of a quarter turn per beam
    send(coef_item(sbmf_pkg::CoefRmin, 32'd0));
    send(coef_item(sbmf_pkg::CoefRmax, 32'd4000));
    send(coef_item(sbmf_pkg::CoefAStart, 32'd0));
    send(coef_item(sbmf_pkg::CoefAStep, 32'h0000_4000));
    send(coef_item(sbmf_pkg::CoefR00, 32'd16384));
    send(coef_item(sbmf_pkg::CoefR00 + 4'd3, 32'd16384));
    send(coef_item(4'd15, 32'hFFFF_FFFF));
    send(sample_item(16'd100, 1'b1, 1'b1));
    send(sample_item(16'd200, 1'b1, 1'b0));
    send(sample_item(16'd300, 1'b1, 1'b0));
    send(sample_item(16'd250, 1'b1, 1'b0));
    send(sample_item(16'd4000, 1'b1, 1'b0));
    send(sample_item(16'd4001, 1'b1, 1'b0));
    send(sample_item(16'd100, 1'b0, 1'b0));
    send(coef_item(sbmf_pkg::CoefRmin, 32'd50));
    send(sample_item(16'd49, 1'b1, 1'b1));
    send(sample_item(16'd50, 1'b1, 1'b0));
    send(coef_item(sbmf_pkg::CoefTx + 4'd2, 32'h8000_0000));
    send(sample_item(16'd60, 1'b1, 1'b0));
    random_phase(400, 1'b0);
    settle();

    // Widest box: the full 16-bit signed range on every axis
    write_box(-32768, 32767, -32768, 32767, -32768, 32767, 1'b0);
    // Long scan of non-finite beams to run the count well up
    for (int i = 0; i < 300; i++) send(sample_item(16'($urandom), 1'b0, i == 0));
    random_phase(400, 1'b0);
    settle();

    write_box($urandom_range(0, 800) - 800, $urandom_range(0, 800), $urandom_range(0, 800) - 800,
              $urandom_range(0, 800), $urandom_range(0, 800) - 800, $urandom_range(0, 800),
              $urandom_range(0, 1));
    random_phase(400, 1'b1);
    settle();

    // Empty box (min above max), outside masked
    write_box(32767, -32768, 32767, -32768, 32767, -32768, 1'b1);
    random_phase(250, 1'b0);
    settle();
    write_box(-500, 300, -350, 350, -200, 350, 1'b1);
    random_phase(250, 1'b0);
    settle();

    $display("Sent %0d beats; %0d results checked, %0d through the transform, %0d masked.",
             n_sent, n_results, n_computed, n_masked);
    if (errors == 0) begin
      $display("scan_box_mask_filter test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("scan_box_mask_filter test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending);
    $display("scan_box_mask_filter test failed");
    $finish;
  end

endmodule
